>>> hdl/ile_pkg.sv
package ile_pkg;

    // action codes carried in the input word
    typedef logic [2:0] t_action;
    localparam t_action ACT_APPEND    = 3'd0;
    localparam t_action ACT_ADD_FRONT = 3'd1;
    localparam t_action ACT_DEL_LAST  = 3'd2;
    localparam t_action ACT_DEL_FIRST = 3'd3;
    localparam t_action ACT_READ      = 3'd4;
    localparam t_action ACT_WRITE     = 3'd5;
    localparam t_action ACT_INSERT    = 3'd6;
    localparam t_action ACT_DEL_AT    = 3'd7;

    // what the datapath has to do with an accepted word
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PLACE  = 2'd0;
    localparam t_kind KIND_REMOVE = 2'd1;
    localparam t_kind KIND_READ   = 2'd2;
    localparam t_kind KIND_WRITE  = 2'd3;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 104;

    typedef struct packed {
        logic s_ready;
        logic load;
        logic up_rd;
        logic up_wr;
        logic put;
        logic dn_rd;
        logic dn_wr;
        logic drop;
        logic get_rd;
        logic get_cap;
        logic rf_zero;
        logic rf_head;
        logic rf_tail;
        logic rf_end;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic  in_ok;
        t_kind in_kind;
        logic  up_done;
        logic  dn_done;
        logic  empty;
        logic  out_free;
    } t_status;

endpackage

>>> hdl/ile_ram.sv
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/ile_ctrl.sv
module ile_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_valid,
    input  ile_pkg::t_status i_status,
    output ile_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP      = 4'd1;
    localparam logic [3:0] S_UP_WR   = 4'd2;
    localparam logic [3:0] S_DN      = 4'd3;
    localparam logic [3:0] S_DN_WR   = 4'd4;
    localparam logic [3:0] S_GET     = 4'd5;
    localparam logic [3:0] S_GET_CAP = 4'd6;
    localparam logic [3:0] S_RF_HEAD = 4'd7;
    localparam logic [3:0] S_RF_TAIL = 4'd8;
    localparam logic [3:0] S_RF_END  = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.in_ok) begin
                        n_state = S_DONE;
                    end else begin
                        case (i_status.in_kind)
                            ile_pkg::KIND_PLACE:  n_state = S_UP;
                            ile_pkg::KIND_WRITE:  n_state = S_UP;
                            ile_pkg::KIND_REMOVE: n_state = S_DN;
                            ile_pkg::KIND_READ:   n_state = S_GET;
                            default:              n_state = S_DONE;
                        endcase
                    end
                end
            end
            // shift entries up one place, top first, until the gap reaches the target
            S_UP: begin
                if (i_status.up_done) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_RF_HEAD;
                end else begin
                    o_cmd.up_rd = 1'b1;
                    n_state     = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.up_wr = 1'b1;
                n_state     = S_UP;
            end
            S_DN: begin
                if (i_status.dn_done) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_RF_HEAD;
                end else begin
                    o_cmd.dn_rd = 1'b1;
                    n_state     = S_DN_WR;
                end
            end
            S_DN_WR: begin
                o_cmd.dn_wr = 1'b1;
                n_state     = S_DN;
            end
            S_GET: begin
                o_cmd.get_rd = 1'b1;
                n_state      = S_GET_CAP;
            end
            S_GET_CAP: begin
                o_cmd.get_cap = 1'b1;
                n_state       = S_DONE;
            end
            // reload head and tail copies after the list changed
            S_RF_HEAD: begin
                if (i_status.empty) begin
                    o_cmd.rf_zero = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.rf_head = 1'b1;
                    n_state       = S_RF_TAIL;
                end
            end
            S_RF_TAIL: begin
                o_cmd.rf_tail = 1'b1;
                n_state       = S_RF_END;
            end
            S_RF_END: begin
                o_cmd.rf_end = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/ile_dpath.sv
module ile_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ile_pkg::t_cmd       i_cmd,
    output ile_pkg::t_status    o_status,
    input  logic [2:0]          i_action,
    input  logic [7:0]          i_position,
    input  logic signed [31:0]  i_item_value,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output logic                o_ok,
    output logic signed [31:0]  o_read_value,
    output logic [4:0]          o_list_count,
    output logic signed [31:0]  o_head_value,
    output logic signed [31:0]  o_tail_value
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    logic [CW-1:0]       r_count;
    logic                r_ok;
    ile_pkg::t_kind      r_kind;
    logic [AW-1:0]       r_pos;
    logic [AW-1:0]       r_idx;
    logic signed [31:0]  r_val;
    logic signed [31:0]  r_rd;
    logic signed [31:0]  r_head;
    logic signed [31:0]  r_tail;

    logic [CMPW-1:0]     cnt_ext;
    logic [CMPW-1:0]     pos_ext;
    logic                full;
    logic                empty;
    logic                chk_ok;
    ile_pkg::t_kind      chk_kind;
    logic [AW-1:0]       chk_pos;
    logic [AW-1:0]       chk_idx;

    logic                mem_we;
    logic [AW-1:0]       mem_raddr;
    logic [31:0]         mem_wdata;
    logic [31:0]         mem_rdata;

    assign cnt_ext = CMPW'(r_count);
    assign pos_ext = CMPW'(i_position);
    assign full    = (r_count == CW'(CAPACITY));
    assign empty   = (r_count == '0);

    // decode and range check of the incoming word against the current count
    always_comb begin
        chk_ok   = 1'b0;
        chk_kind = ile_pkg::KIND_READ;
        chk_pos  = AW'(i_position);
        case (i_action)
            ile_pkg::ACT_APPEND: begin
                chk_kind = ile_pkg::KIND_PLACE;
                chk_ok   = !full;
                chk_pos  = AW'(r_count);
            end
            ile_pkg::ACT_ADD_FRONT: begin
                chk_kind = ile_pkg::KIND_PLACE;
                chk_ok   = !full;
                chk_pos  = '0;
            end
            ile_pkg::ACT_DEL_LAST: begin
                chk_kind = ile_pkg::KIND_REMOVE;
                chk_ok   = !empty;
                chk_pos  = AW'(r_count - CW'(1));
            end
            ile_pkg::ACT_DEL_FIRST: begin
                chk_kind = ile_pkg::KIND_REMOVE;
                chk_ok   = !empty;
                chk_pos  = '0;
            end
            ile_pkg::ACT_READ: begin
                chk_kind = ile_pkg::KIND_READ;
                chk_ok   = (pos_ext < cnt_ext);
            end
            ile_pkg::ACT_WRITE: begin
                chk_kind = ile_pkg::KIND_WRITE;
                chk_ok   = (pos_ext < cnt_ext);
            end
            ile_pkg::ACT_INSERT: begin
                chk_kind = ile_pkg::KIND_PLACE;
                chk_ok   = !full && (pos_ext <= cnt_ext);
            end
            ile_pkg::ACT_DEL_AT: begin
                chk_kind = ile_pkg::KIND_REMOVE;
                chk_ok   = (pos_ext < cnt_ext);
            end
            default: begin
                chk_ok = 1'b0;
            end
        endcase
    end

    // a place starts its shift from the top slot; the others work at the position
    assign chk_idx = (chk_kind == ile_pkg::KIND_PLACE) ? AW'(r_count) : chk_pos;

    always_comb begin
        mem_raddr = '0;
        if (i_cmd.up_rd) begin
            mem_raddr = r_idx - AW'(1);
        end else if (i_cmd.dn_rd) begin
            mem_raddr = r_idx + AW'(1);
        end else if (i_cmd.get_rd) begin
            mem_raddr = r_pos;
        end else if (i_cmd.rf_head) begin
            mem_raddr = '0;
        end else if (i_cmd.rf_tail) begin
            mem_raddr = AW'(r_count - CW'(1));
        end
    end

    assign mem_we    = i_cmd.up_wr || i_cmd.dn_wr || i_cmd.put;
    assign mem_wdata = i_cmd.put ? r_val : mem_rdata;

    ile_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_idx),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= chk_kind;
            r_ok   <= chk_ok;
            r_pos  <= chk_pos;
            r_idx  <= chk_idx;
            r_val  <= i_item_value;
            r_rd   <= '0;
        end else if (i_cmd.up_wr) begin
            r_idx <= r_idx - AW'(1);
        end else if (i_cmd.dn_wr) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.get_cap) begin
            r_rd <= mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            if (i_cmd.put && r_kind == ile_pkg::KIND_PLACE) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.drop) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.rf_zero) begin
                r_head <= '0;
                r_tail <= '0;
            end
            // head read was issued the cycle before
            if (i_cmd.rf_tail) begin
                r_head <= mem_rdata;
            end
            if (i_cmd.rf_end) begin
                r_tail <= mem_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ok         <= r_ok;
            o_read_value <= r_rd;
            o_list_count <= 5'(r_count);
            o_head_value <= r_head;
            o_tail_value <= r_tail;
        end
    end

    assign o_status.in_ok    = chk_ok;
    assign o_status.in_kind  = chk_kind;
    assign o_status.up_done  = (r_idx == r_pos);
    assign o_status.dn_done  = ((CW'(r_idx) + CW'(1)) >= r_count);
    assign o_status.empty    = empty;
    assign o_status.out_free = !o_m_valid || i_m_ready;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_place_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.put && r_kind == ile_pkg::KIND_PLACE) |=> r_count == $past(r_count) + CW'(1))
        else $error("place did not grow the list");

    a_drop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drop |=> r_count == $past(r_count) - CW'(1))
        else $error("removal did not shrink the list");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_valid && o_list_count == 5'd0 && CW <= 5)
        |-> (o_head_value == 0 && o_tail_value == 0))
        else $error("empty list reports nonzero head or tail");

endmodule

>>> hdl/indexed_list_engine.sv
// From accepted word to result valid: a failed action goes straight to the result; a read
// does one registered RAM read; a write stores the item in place, then reloads head/tail; an
// add or delete does one registered RAM read and one write per moved entry, then places the
// item or shrinks the count and reloads head/tail (a delete that empties the list clears them).
// A new word is taken no earlier than the cycle after the previous result is loaded into the output register.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending result.
module indexed_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // action[2:0], position[10:3], item_value[42:11], zero pad
    input  logic [ile_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ok[0], read_value[32:1], list_count[37:33], head_value[69:38],
    // tail_value[101:70], zero pad
    output logic [ile_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    ile_pkg::t_cmd    cmd;
    ile_pkg::t_status status;

    logic               ok;
    logic signed [31:0] read_value;
    logic [4:0]         list_count;
    logic signed [31:0] head_value;
    logic signed [31:0] tail_value;

    ile_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_axis_tvalid),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ile_dpath #(
        .CAPACITY(CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_action    (s_axis_tdata[2:0]),
        .i_position  (s_axis_tdata[10:3]),
        .i_item_value(s_axis_tdata[42:11]),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_ok        (ok),
        .o_read_value(read_value),
        .o_list_count(list_count),
        .o_head_value(head_value),
        .o_tail_value(tail_value)
    );

    assign s_axis_tready = cmd.s_ready;
    assign m_axis_tdata  = {2'b00, tail_value, head_value, list_count, read_value, ok};

endmodule
